@@ sv/etac_pkg.sv @@
package etac_pkg;

  // block dimensions
  localparam int CHUNK     = 256;
  localparam int ADDR_BITS = 17;

  // fixed field widths
  localparam int GAIN_W   = 8;
  localparam int THR_W    = 16;
  localparam int LEN_W    = 18;
  localparam int ADDR_W   = 17;
  localparam int SAMPLE_W = 16;
  localparam int MAG_W    = 16;
  localparam int ENERGY_W = 24;
  localparam int WORD_W   = 32;
  localparam int CFG_W    = 18;
  localparam int CFG_IDX_W = 2;

  // chunk position counter and trigger level widths
  localparam int CHUNK_W   = (CHUNK > 2) ? $clog2(CHUNK) : 1;
  localparam int SCALED_W  = THR_W + 1 + $clog2(CHUNK + 1);
  localparam int LEVEL_W   = (SCALED_W > ENERGY_W) ? SCALED_W : ENERGY_W + 1;

  localparam logic [ADDR_W-1:0]   ADDR_MASK   = ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [CHUNK_W-1:0]  CHUNK_LAST  = CHUNK_W'(CHUNK - 1);
  localparam logic [LEN_W-1:0]    CHUNK_COUNT = LEN_W'(CHUNK);
  localparam logic [ENERGY_W-1:0] ENERGY_MAX  = {ENERGY_W{1'b1}};

  // register reset values
  localparam logic [GAIN_W-1:0] GAIN_RST   = GAIN_W'(1);
  localparam logic [THR_W-1:0]  THR_RST    = THR_W'(5000);
  localparam logic [LEN_W-1:0]  LENGTH_RST = LEN_W'(80000);

  // sample saturation limits
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  // operation codes
  localparam logic OP_AUDIO  = 1'b0;
  localparam logic OP_RESUME = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN      = 2'd0,
    CFG_THRESHOLD = 2'd1,
    CFG_LENGTH    = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_LISTEN = 2'd0,
    MODE_RECORD = 2'd1,
    MODE_FULL   = 2'd2
  } mode_t;

  // amplifier result
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [MAG_W-1:0]           mag;
  } amp_res_t;

  // trigger level: floor(sum / CHUNK) > thr  <=>  sum >= (thr + 1) * CHUNK
  function automatic logic [LEVEL_W-1:0] trigger_level(input logic [THR_W-1:0] thr);
    trigger_level = (LEVEL_W'(thr) + LEVEL_W'(1)) * LEVEL_W'(CHUNK);
  endfunction

endpackage

@@ sv/etac_amp.sv @@
module etac_amp (
  input  logic signed [etac_pkg::WORD_W-1:0] raw_word,
  input  logic [etac_pkg::GAIN_W-1:0]        gain,
  output etac_pkg::amp_res_t                 res
);

  logic signed [etac_pkg::SAMPLE_W-1:0]                  hi;
  logic signed [etac_pkg::SAMPLE_W+etac_pkg::GAIN_W:0]   prod;
  logic signed [etac_pkg::SAMPLE_W-1:0]                  sat;

  // upper half times gain
  assign hi   = raw_word[etac_pkg::WORD_W-1 -: etac_pkg::SAMPLE_W];
  assign prod = (etac_pkg::SAMPLE_W+etac_pkg::GAIN_W+1)'(hi)
              * (etac_pkg::SAMPLE_W+etac_pkg::GAIN_W+1)'($signed({1'b0, gain}));

  // clamp to 16 bits and take magnitude
  always_comb begin
    if (prod > $signed({{(etac_pkg::GAIN_W+1){1'b0}}, etac_pkg::SAMPLE_MAX})) begin
      sat = etac_pkg::SAMPLE_MAX;
    end else if (prod < $signed({{(etac_pkg::GAIN_W+1){1'b1}}, etac_pkg::SAMPLE_MIN})) begin
      sat = etac_pkg::SAMPLE_MIN;
    end else begin
      sat = prod[etac_pkg::SAMPLE_W-1:0];
    end
    res.sample = sat;
    res.mag    = sat[etac_pkg::SAMPLE_W-1] ? (~sat + 16'd1) : sat;
  end

endmodule

@@ sv/energy_triggered_audio_capture_top.sv @@
// Energy-triggered audio capture. Each request carries one I2S word (or a resume
// command); the upper 16 bits are scaled by gain and clamped to 16 bits. While
// listening, each chunk of CHUNK samples is written to addresses 0..CHUNK-1 and its
// absolute sum checked against the threshold; a chunk whose mean is above it starts
// recording at address CHUNK until capture_length samples are stored, then the block
// holds full until a resume request. Every request gives exactly one result. Rate is
// one request per clock unless the output stalls; input register, then result
// register, with the multiply, clamp, accumulate and compare path setting the clock.
// Configuration writes are always ready and take effect on the next request.
module energy_triggered_audio_capture_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_operation,
  input  logic signed [etac_pkg::WORD_W-1:0]  in_raw_word,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_write_enable,
  output logic [etac_pkg::ADDR_W-1:0]         out_write_address,
  output logic signed [etac_pkg::SAMPLE_W-1:0] out_sample_out,
  output logic [1:0]                          out_mode_now,
  output logic                                out_triggered,
  output logic                                out_capture_done,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [etac_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [etac_pkg::CFG_W-1:0]          cfg_data
);

  // configuration
  logic [etac_pkg::GAIN_W-1:0]  gain_r;
  logic [etac_pkg::LEVEL_W-1:0] level_r;
  logic [etac_pkg::LEN_W-1:0]   length_r;

  // input stage
  logic                               s1_valid_r;
  logic                               s1_op_r;
  logic signed [etac_pkg::WORD_W-1:0] s1_word_r;

  // capture state
  etac_pkg::mode_t               mode_r, mode_nxt;
  logic [etac_pkg::CHUNK_W-1:0]  pos_r, pos_nxt;
  logic [etac_pkg::ENERGY_W-1:0] energy_r, energy_nxt;
  logic [etac_pkg::LEN_W-1:0]    count_r, count_nxt;

  // result stage
  logic                                 out_valid_r;
  logic                                 we_r, we_nxt;
  logic [etac_pkg::ADDR_W-1:0]          addr_r, addr_nxt;
  logic signed [etac_pkg::SAMPLE_W-1:0] sample_r, sample_nxt;
  logic [1:0]                           mode_out_r;
  logic                                 trig_r, trig_nxt;
  logic                                 done_r, done_nxt;

  logic                                 adv;
  etac_pkg::amp_res_t                   amp;
  logic [etac_pkg::ENERGY_W:0]          energy_add;
  logic [etac_pkg::ENERGY_W-1:0]        energy_sat;
  logic [etac_pkg::LEN_W-1:0]           count_inc;

  // handshakes
  assign adv       = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || adv;
  assign cfg_ready = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= etac_pkg::GAIN_RST;
      level_r  <= etac_pkg::trigger_level(etac_pkg::THR_RST);
      length_r <= etac_pkg::LENGTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        etac_pkg::CFG_GAIN:      gain_r   <= cfg_data[etac_pkg::GAIN_W-1:0];
        etac_pkg::CFG_THRESHOLD: level_r  <=
          etac_pkg::trigger_level(cfg_data[etac_pkg::THR_W-1:0]);
        etac_pkg::CFG_LENGTH:    length_r <= cfg_data[etac_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op_r   <= in_operation;
      s1_word_r <= in_raw_word;
    end
  end

  etac_amp u_amp (
    .raw_word (s1_word_r),
    .gain     (gain_r),
    .res      (amp)
  );

  // saturating chunk energy
  assign energy_add = {1'b0, energy_r} + (etac_pkg::ENERGY_W+1)'(amp.mag);
  assign energy_sat = energy_add[etac_pkg::ENERGY_W] ? etac_pkg::ENERGY_MAX
                                                     : energy_add[etac_pkg::ENERGY_W-1:0];
  assign count_inc  = count_r + etac_pkg::LEN_W'(1);

  // capture control
  always_comb begin
    mode_nxt   = mode_r;
    pos_nxt    = pos_r;
    energy_nxt = energy_r;
    count_nxt  = count_r;
    we_nxt     = 1'b0;
    addr_nxt   = '0;
    sample_nxt = '0;
    trig_nxt   = 1'b0;
    done_nxt   = 1'b0;
    if (s1_op_r == etac_pkg::OP_RESUME) begin
      if (mode_r != etac_pkg::MODE_LISTEN && mode_r != etac_pkg::MODE_RECORD) begin
        mode_nxt   = etac_pkg::MODE_LISTEN;
        pos_nxt    = '0;
        energy_nxt = '0;
        count_nxt  = '0;
      end
    end else begin
      sample_nxt = amp.sample;
      case (mode_r)
        etac_pkg::MODE_LISTEN: begin
          we_nxt   = 1'b1;
          addr_nxt = etac_pkg::ADDR_W'(pos_r) & etac_pkg::ADDR_MASK;
          if (pos_r == etac_pkg::CHUNK_LAST) begin
            pos_nxt    = '0;
            energy_nxt = '0;
            if (etac_pkg::LEVEL_W'(energy_sat) >= level_r) begin
              trig_nxt  = 1'b1;
              count_nxt = etac_pkg::CHUNK_COUNT;
              if (etac_pkg::CHUNK_COUNT >= length_r) begin
                mode_nxt = etac_pkg::MODE_FULL;
                done_nxt = 1'b1;
              end else begin
                mode_nxt = etac_pkg::MODE_RECORD;
              end
            end
          end else begin
            pos_nxt    = pos_r + etac_pkg::CHUNK_W'(1);
            energy_nxt = energy_sat;
          end
        end
        etac_pkg::MODE_RECORD: begin
          if (count_r >= length_r) begin
            mode_nxt = etac_pkg::MODE_FULL;
            done_nxt = 1'b1;
          end else begin
            we_nxt    = 1'b1;
            addr_nxt  = count_r[etac_pkg::ADDR_W-1:0] & etac_pkg::ADDR_MASK;
            count_nxt = count_inc;
            if (count_inc >= length_r) begin
              mode_nxt = etac_pkg::MODE_FULL;
              done_nxt = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= etac_pkg::MODE_LISTEN;
      pos_r       <= '0;
      energy_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        mode_r   <= mode_nxt;
        pos_r    <= pos_nxt;
        energy_r <= energy_nxt;
        count_r  <= count_nxt;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (adv) begin
      we_r       <= we_nxt;
      addr_r     <= addr_nxt;
      sample_r   <= sample_nxt;
      mode_out_r <= mode_nxt;
      trig_r     <= trig_nxt;
      done_r     <= done_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_write_enable  = we_r;
  assign out_write_address = addr_r;
  assign out_sample_out    = sample_r;
  assign out_mode_now      = mode_out_r;
  assign out_triggered     = trig_r;
  assign out_capture_done  = done_r;

  // checks
  a_trig_leaves_listen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && trig_r |-> mode_out_r != etac_pkg::MODE_LISTEN)
    else $error("trigger reported while still listening");

  a_done_is_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && done_r |-> mode_out_r == etac_pkg::MODE_FULL)
    else $error("capture done without full mode");

  a_no_write_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !we_r |-> addr_r == '0)
    else $error("address set on a result without a write");

  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    adv && mode_r == etac_pkg::MODE_FULL && s1_op_r == etac_pkg::OP_AUDIO
    |=> mode_r == etac_pkg::MODE_FULL)
    else $error("full mode left without a resume");

  a_pos_only_listening: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r != '0 |-> mode_r == etac_pkg::MODE_LISTEN)
    else $error("chunk position nonzero outside listening");

endmodule
